// ===== src/ncc_pkg.sv =====
// shared constants, codes and types of the nearest-centroid classifier
`timescale 1ns / 1ps

package ncc_pkg;

	localparam int MAX_CLUSTERS = 16;
	localparam int MAX_DIMS     = 16;
	localparam int COORD_BITS   = 16;

	// fixed field widths of the ports
	localparam int CFG_W    = 5;
	localparam int CL_IN_W  = 4;
	localparam int DIM_IN_W = 4;
	localparam int VAL_W    = 16;
	localparam int LABEL_W  = 4;
	localparam int DIST_W   = 40;
	localparam int CFG_RESET = 16;

	localparam int CL_W      = (MAX_CLUSTERS > 1) ? $clog2(MAX_CLUSTERS) : 1;
	localparam int DIM_W     = (MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1;
	localparam int CL_CNT_W  = $clog2(MAX_CLUSTERS + 1);
	localparam int DIM_CNT_W = $clog2(MAX_DIMS + 1);
	localparam int DEPTH     = MAX_CLUSTERS * MAX_DIMS;
	localparam int ADDR_W    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int MAG_W     = COORD_BITS + 1;
	localparam int SQ_W      = 2 * MAG_W;

	localparam logic [DIST_W-1:0] DIST_MAX = '1;
	localparam logic [63:0]       SQ_LIMIT = 64'd1 << 20;

	typedef logic [COORD_BITS-1:0] coord_t;
	typedef logic [DIST_W-1:0]     dist_t;

	typedef enum logic {
		REG_ACTIVE_CLUSTERS = 1'b0,
		REG_ACTIVE_DIMS     = 1'b1
	} cfg_reg_t;

	typedef enum logic {
		REQ_CENTROID = 1'b0,
		REQ_POINT    = 1'b1
	} req_t;

	// control that travels with each centroid coordinate through the datapath
	typedef struct packed {
		logic            valid;
		logic            first_dim;
		logic            last_dim;
		logic            first_cl;
		logic            last_cl;
		logic [CL_W-1:0] cl;
	} ncc_ctl_t;

endpackage

// ===== src/ncc_centroid_ram.sv =====
// centroid table: one write port, one registered read port, per-entry valid bits
`timescale 1ns / 1ps

module ncc_centroid_ram (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  wr_en,
	input  logic [ncc_pkg::ADDR_W-1:0] wr_addr,
	input  ncc_pkg::coord_t       wr_data,
	input  logic                  rd_en,
	input  logic [ncc_pkg::ADDR_W-1:0] rd_addr,
	output ncc_pkg::coord_t       rd_data
);
	import ncc_pkg::*;

	coord_t             mem [DEPTH];
	logic [DEPTH-1:0]   valid_q;
	coord_t             rd_data_q;
	logic               rd_valid_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	// entries never written read as zero
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q    <= '0;
			rd_valid_q <= 1'b0;
		end else begin
			if (wr_en) begin
				valid_q[wr_addr] <= 1'b1;
			end
			if (rd_en) begin
				rd_valid_q <= valid_q[rd_addr];
			end
		end
	end

	assign rd_data = rd_valid_q ? rd_data_q : '0;

endmodule

// ===== src/ncc_dist_pipe.sv =====
// distance datapath: square, accumulate, keep the best centroid
`timescale 1ns / 1ps

module ncc_dist_pipe (
	input  logic                        clk,
	input  logic                        arst_n,
	input  ncc_pkg::ncc_ctl_t           ctl_s0,
	input  ncc_pkg::coord_t             pt_s0,
	input  ncc_pkg::coord_t             cent_s1,
	output logic                        done,
	output logic [ncc_pkg::LABEL_W-1:0] label,
	output ncc_pkg::dist_t              best_dist
);
	import ncc_pkg::*;

	ncc_ctl_t            ctl_s1, ctl_s2, ctl_s3;
	coord_t              pt_s1;
	logic signed [MAG_W-1:0] diff;
	logic [MAG_W-1:0]    mag;
	logic [SQ_W-1:0]     prod;
	dist_t               sq, sq_s2;
	dist_t               base, acc_n, acc_s3;
	dist_t               best_q;
	logic [CL_W-1:0]     best_cl_q;
	logic                take;
	logic                done_q;
	logic [LABEL_W-1:0]  label_q;
	dist_t               dist_q;

	always_comb begin
		diff = $signed({pt_s1[COORD_BITS-1], pt_s1})
			- $signed({cent_s1[COORD_BITS-1], cent_s1});
		mag  = diff[MAG_W-1] ? MAG_W'(-diff) : MAG_W'(diff);
		prod = SQ_W'(mag) * SQ_W'(mag);
		sq   = (64'(mag) >= SQ_LIMIT) ? DIST_MAX : DIST_W'(prod);
	end

	// saturating running sum, restarted at the first coordinate
	always_comb begin
		base  = ctl_s2.first_dim ? '0 : acc_s3;
		acc_n = (sq_s2 >= DIST_MAX - base) ? DIST_MAX : base + sq_s2;
	end

	assign take = ctl_s3.valid && ctl_s3.last_dim && (ctl_s3.first_cl || acc_s3 < best_q);

	always_ff @(posedge clk) begin
		pt_s1  <= pt_s0;
		sq_s2  <= sq;
		if (ctl_s2.valid) begin
			acc_s3 <= acc_n;
		end
		if (take) begin
			best_q    <= acc_s3;
			best_cl_q <= ctl_s3.cl;
		end
		label_q <= take ? LABEL_W'(ctl_s3.cl) : LABEL_W'(best_cl_q);
		dist_q  <= take ? acc_s3 : best_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '0;
			ctl_s2 <= '0;
			ctl_s3 <= '0;
			done_q <= 1'b0;
		end else begin
			ctl_s1 <= ctl_s0;
			ctl_s2 <= ctl_s1;
			ctl_s3 <= ctl_s2;
			done_q <= ctl_s3.valid && ctl_s3.last_dim && ctl_s3.last_cl;
		end
	end

	assign done      = done_q;
	assign label     = label_q;
	assign best_dist = dist_q;

endmodule

// ===== src/nearest_centroid_classifier.sv =====
// top level: command port, configuration, point buffer and search sequencer
`timescale 1ns / 1ps

// Nearest-centroid classifier. A beat is taken at a rising edge with start
// high and busy low. Centroid beats and point beats that do not complete the
// point leave busy low. A point beat at dimension active_dims-1 starts a
// search: the sequencer reads one centroid coordinate per cycle from the
// centroid memory, so the search issues active_clusters * active_dims reads;
// done pulses for one cycle once the last read has passed the distance
// datapath, with nearest_label and best_sq_distance valid in that cycle. The
// receiver cannot stall, so the result must be captured in that cycle. busy
// drops the cycle after done. Beats with dim_index at or beyond active_dims
// are dropped without a result.
// Configuration writes must only be issued while busy is low.
module nearest_centroid_classifier (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	output logic                         busy,
	input  logic                         req_type,
	input  logic [ncc_pkg::CL_IN_W-1:0]  cluster_index,
	input  logic [ncc_pkg::DIM_IN_W-1:0] dim_index,
	input  logic signed [ncc_pkg::VAL_W-1:0] coord_value,
	output logic                         done,
	output logic [ncc_pkg::LABEL_W-1:0]  nearest_label,
	output logic [ncc_pkg::DIST_W-1:0]   best_sq_distance,
	input  logic                         cfg_we,
	input  logic                         cfg_index,
	input  logic [ncc_pkg::CFG_W-1:0]    cfg_data
);
	import ncc_pkg::*;

	// configuration registers, raw as written
	logic [CFG_W-1:0]     clusters_q;
	logic [CFG_W-1:0]     dims_q;
	// effective counts after clamping into 1..max
	logic [CL_CNT_W-1:0]  eff_cl;
	logic [DIM_CNT_W-1:0] eff_dims;

	// command decode
	logic                 accept;
	logic                 in_range;
	logic                 cent_wr;
	logic                 pt_wr;
	logic                 trigger;
	coord_t               coord;

	// point buffer, cleared at reset
	coord_t               point_q [MAX_DIMS];

	// search sequencer
	logic                 busy_q;
	logic                 issue_q;
	logic [CL_W-1:0]      c_q;
	logic [DIM_W-1:0]     d_q;
	logic                 last_d;
	logic                 last_c;
	ncc_ctl_t             ctl_s0;

	logic [ADDR_W-1:0]    wr_addr;
	logic [ADDR_W-1:0]    rd_addr;
	coord_t               cent_s1;
	logic                 pipe_done;

	function automatic int clamp_count(logic [CFG_W-1:0] v, int max);
		int r;
		r = 32'(v);
		if (v == '0) begin
			r = 1;
		end else if (r > max) begin
			r = max;
		end
		return r;
	endfunction

	assign eff_cl   = CL_CNT_W'(clamp_count(clusters_q, MAX_CLUSTERS));
	assign eff_dims = DIM_CNT_W'(clamp_count(dims_q, MAX_DIMS));

	// config writes, which the user must issue only while idle; the block does not enforce it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clusters_q <= CFG_W'(CFG_RESET);
			dims_q     <= CFG_W'(CFG_RESET);
		end else if (cfg_we) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_ACTIVE_CLUSTERS: clusters_q <= cfg_data;
				REG_ACTIVE_DIMS:     dims_q     <= cfg_data;
			endcase
		end
	end

	// low coord_bits of the beat taken as a signed value
	assign coord    = COORD_BITS'(coord_value);
	assign accept   = start && !busy_q;
	assign in_range = 32'(dim_index) < 32'(eff_dims);
	assign cent_wr  = accept && in_range && (req_type == REQ_CENTROID)
		&& (32'(cluster_index) < MAX_CLUSTERS);
	assign pt_wr    = accept && in_range && (req_type == REQ_POINT);
	assign trigger  = pt_wr && (32'(dim_index) == 32'(eff_dims) - 1);

	assign wr_addr  = ADDR_W'(32'(cluster_index) * MAX_DIMS + 32'(dim_index));
	assign rd_addr  = ADDR_W'(32'(c_q) * MAX_DIMS + 32'(d_q));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < MAX_DIMS; i++) begin
				point_q[i] <= '0;
			end
		end else if (pt_wr) begin
			point_q[DIM_W'(dim_index)] <= coord;
		end
	end

	// walk dims inside clusters, one centroid coordinate per cycle
	assign last_d = (32'(d_q) == 32'(eff_dims) - 1);
	assign last_c = (32'(c_q) == 32'(eff_cl) - 1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q  <= 1'b0;
			issue_q <= 1'b0;
			c_q     <= '0;
			d_q     <= '0;
		end else begin
			if (trigger) begin
				busy_q  <= 1'b1;
				issue_q <= 1'b1;
				c_q     <= '0;
				d_q     <= '0;
			end else if (issue_q) begin
				if (last_d) begin
					d_q <= '0;
					if (last_c) begin
						issue_q <= 1'b0;
					end else begin
						c_q <= c_q + 1'b1;
					end
				end else begin
					d_q <= d_q + 1'b1;
				end
			end
			// result beat leaves this cycle, idle from the next
			if (pipe_done) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_comb begin
		ctl_s0.valid     = issue_q;
		ctl_s0.first_dim = (d_q == '0);
		ctl_s0.last_dim  = last_d;
		ctl_s0.first_cl  = (c_q == '0);
		ctl_s0.last_cl   = last_c;
		ctl_s0.cl        = c_q;
	end

	ncc_centroid_ram u_ram (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (cent_wr),
		.wr_addr (wr_addr),
		.wr_data (coord),
		.rd_en   (issue_q),
		.rd_addr (rd_addr),
		.rd_data (cent_s1)
	);

	ncc_dist_pipe u_pipe (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctl_s0    (ctl_s0),
		.pt_s0     (point_q[d_q]),
		.cent_s1   (cent_s1),
		.done      (pipe_done),
		.label     (nearest_label),
		.best_dist (best_sq_distance)
	);

	assign busy = busy_q;
	assign done = pipe_done;

	// a result only comes out of a running search
	a_done_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> busy)
		else $error("result beat outside a search");

	// busy ends only right after the result beat
	a_busy_end: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(busy_q) |-> $past(pipe_done))
		else $error("search ended without a result beat");

	// reads are only issued inside a search, at an active centroid
	a_issue_busy: assert property (@(posedge clk) disable iff (!arst_n)
		issue_q |-> busy_q && (32'(c_q) < 32'(eff_cl)) && (32'(d_q) < 32'(eff_dims)))
		else $error("read issued outside the active table");

	// no write to the centroid table or the point buffer while a search runs
	a_no_wr_search: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> !cent_wr && !pt_wr)
		else $error("store written during a search");

endmodule
